// File: hdl/clocked_serial_loader_framer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clocked serial loader framer
// Shared property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef CLOCKED_SERIAL_LOADER_FRAMER_CORE_MACROS_SVH
`define CLOCKED_SERIAL_LOADER_FRAMER_CORE_MACROS_SVH

// Checked only while out of reset.
`define CLSF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define CLSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/clsf_pkg.sv
// ----------------------------------------------------------------------------
// clsf_pkg
// Types, codes and constants of the clocked serial loader framer.
// ----------------------------------------------------------------------------
`default_nettype none

package clsf_pkg;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned LEN_W      = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MAX_FRAMES = 4;
  localparam int unsigned FRAME_BITS = 11;
  localparam int unsigned BIT_IDX_W  = 4;
  localparam int unsigned NFRM_W     = 3;

  localparam logic [ADDR_W-1:0] START_ADDR_RST = 16'h8200;
  localparam logic [LEN_W-1:0]  IMAGE_LEN_RST  = 15'd1;
  // clamp on the length used for the end address
  localparam logic [16:0]       MAX_IMAGE      = 17'd16384;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_IDLE  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ADDRESS = 2'd0,
    REG_IMAGE_LENGTH  = 2'd1
  } cfg_reg_t;

  // one load into the serialiser: either a single mark bit or up to four frames
  typedef struct packed {
    logic                         idle;
    logic [NFRM_W-1:0]            nfrm;
    logic [MAX_FRAMES-1:0][7:0]   frm;
  } clsf_load_t;

  // level of bit idx within a frame: start, eight data bits LSB first, two stops
  function automatic logic frame_bit(input logic [7:0] byte_v,
                                     input logic [BIT_IDX_W-1:0] idx);
    logic [BIT_IDX_W-1:0] k;
    logic                 b;
    k = idx - 4'd1;
    if (idx == 4'd0) begin
      b = 1'b0;
    end else if (idx <= 4'd8) begin
      b = byte_v[k[2:0]];
    end else begin
      b = 1'b1;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hdl/clsf_in_if.sv
// ----------------------------------------------------------------------------
// clsf_in_if
// Input word channel: item kind, data byte and last-byte flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface clsf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, kind, data_byte, final_byte, input ready);
  modport sink   (input valid, kind, data_byte, final_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/clsf_out_if.sv
// ----------------------------------------------------------------------------
// clsf_out_if
// Result word channel: one serial bit period per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface clsf_out_if;
  logic valid;
  logic ready;
  logic line_bit;
  logic run_end;

  modport source (output valid, line_bit, run_end, input ready);
  modport sink   (input valid, line_bit, run_end, output ready);
endinterface

`default_nettype wire

// File: hdl/clsf_cfg_if.sv
// ----------------------------------------------------------------------------
// clsf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface clsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/clocked_serial_loader_framer_core.sv
// ----------------------------------------------------------------------------
// clocked_serial_loader_framer_core
// Frames a memory image into the clocked serial load stream of a trainer.
// ----------------------------------------------------------------------------
// Every result word is one bit period of the serial line (1 is mark). A data
// word gives one frame (two with the checksum frame if it is the last byte), a
// begin word four header frames and an idle word one mark bit; the serialiser
// shifts one bit per cycle unless the output stalls. A word waits in the input
// register while the previous one is still shifting out and is handed over on
// the last bit, so consecutive words run gap free. Kind 3 words are taken and
// dropped. The user must write configuration only while the block is idle; the
// block does not enforce it. An index beyond the two registers is ignored.
`default_nettype none

module clocked_serial_loader_framer_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  clsf_in_if.sink    in_ch,
  clsf_out_if.source out_ch,
  clsf_cfg_if.sink   cfg_ch
);
  import clsf_pkg::*;

  // configuration registers
  logic [ADDR_W-1:0] start_addr_r;
  logic [LEN_W-1:0]  image_len_r;

  // input register
  logic       a_valid_r, a_valid_nxt;
  logic [1:0] a_kind_r;
  logic [7:0] a_byte_r;
  logic       a_final_r;

  // checksum accumulator
  logic [7:0] sum_r, sum_nxt;

  clsf_load_t ld;
  logic       ld_ready, a_take, in_acc;

  logic [16:0]       len_c;
  logic [ADDR_W-1:0] end_addr;
  logic [7:0]        sh, sl, eh, el, data_sum;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= START_ADDR_RST;
      image_len_r  <= IMAGE_LEN_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_START_ADDRESS: start_addr_r <= cfg_ch.data;
        REG_IMAGE_LENGTH:  image_len_r  <= cfg_ch.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input side: free slot, or the slot empties this cycle
  assign in_ch.ready = !a_valid_r || ld_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign a_take      = a_valid_r && ld_ready;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (a_take) begin
      a_valid_nxt = 1'b0;
    end
    // unused kind is swallowed
    if (in_acc && (in_ch.kind != 2'd3)) begin
      a_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_kind_r  <= in_ch.kind;
      a_byte_r  <= in_ch.data_byte;
      a_final_r <= in_ch.final_byte;
    end
  end

  // header: end address = start + clamped length - 1, wrapping at 16 bits
  always_comb begin
    len_c = {2'b00, image_len_r};
    if (len_c > MAX_IMAGE) begin
      len_c = MAX_IMAGE;
    end
    end_addr = start_addr_r + len_c[ADDR_W-1:0] - 16'd1;
    sh       = start_addr_r[15:8];
    sl       = start_addr_r[7:0];
    eh       = end_addr[15:8];
    el       = end_addr[7:0];
    data_sum = sum_r + a_byte_r;
  end

  // build the serialiser load; frame 0 goes out first
  always_comb begin
    ld      = '0;
    sum_nxt = sum_r;
    case (kind_t'(a_kind_r))
      KIND_BEGIN: begin
        ld.nfrm = NFRM_W'(4);
        ld.frm  = {el, eh, sl, sh};
        sum_nxt = sh + sl + eh + el;
      end
      KIND_DATA: begin
        ld.nfrm = a_final_r ? NFRM_W'(2) : NFRM_W'(1);
        ld.frm  = {8'h00, 8'h00, 8'h00 - data_sum, a_byte_r};
        sum_nxt = data_sum;
      end
      KIND_IDLE: begin
        ld.idle = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (a_take) begin
      sum_r <= sum_nxt;
    end
  end

  clsf_serializer u_ser (
    .clk          (clk),
    .rst_n        (rst_n),
    .ld_valid     (a_valid_r),
    .ld           (ld),
    .ld_ready     (ld_ready),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_line_bit (out_ch.line_bit),
    .out_run_end  (out_ch.run_end)
  );

endmodule

`default_nettype wire

// File: hdl/clsf_serializer.sv
// ----------------------------------------------------------------------------
// clsf_serializer
// Frame queue and bit counter; drives one bit per word into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module clsf_serializer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               ld_valid,
  input  wire clsf_pkg::clsf_load_t ld,
  output logic                    ld_ready,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic                    out_line_bit,
  output logic                    out_run_end
);
  import clsf_pkg::*;

  logic [MAX_FRAMES-1:0][7:0] frm_r,  frm_nxt;
  logic [NFRM_W-1:0]          nfrm_r, nfrm_nxt;
  logic [BIT_IDX_W-1:0]       bit_r,  bit_nxt;
  logic                       idle_r, idle_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       line_r, line_nxt;
  logic                       end_r,  end_nxt;

  logic busy, out_load, adv, cur_bit, last_bit, frame_done;

  always_comb begin
    busy       = idle_r || (nfrm_r != '0);
    out_load   = !out_valid_r || out_ready;
    adv        = busy && out_load;
    frame_done = (bit_r == BIT_IDX_W'(FRAME_BITS - 1));
    cur_bit    = idle_r ? 1'b1 : frame_bit(frm_r[0], bit_r);
    last_bit   = idle_r || (frame_done && (nfrm_r == NFRM_W'(1)));
    ld_ready   = !busy || (adv && last_bit);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    line_nxt      = line_r;
    end_nxt       = end_r;
    frm_nxt       = frm_r;
    nfrm_nxt      = nfrm_r;
    bit_nxt       = bit_r;
    idle_nxt      = idle_r;

    if (adv) begin
      out_valid_nxt = 1'b1;
      line_nxt      = cur_bit;
      end_nxt       = last_bit;
      if (idle_r) begin
        idle_nxt = 1'b0;
      end else if (frame_done) begin
        bit_nxt  = '0;
        nfrm_nxt = nfrm_r - NFRM_W'(1);
        frm_nxt  = frm_r >> 8;
      end else begin
        bit_nxt = bit_r + BIT_IDX_W'(1);
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (ld_valid && ld_ready) begin
      idle_nxt = ld.idle;
      nfrm_nxt = ld.nfrm;
      frm_nxt  = ld.frm;
      bit_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      nfrm_r      <= '0;
      bit_r       <= '0;
      idle_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      nfrm_r      <= nfrm_nxt;
      bit_r       <= bit_nxt;
      idle_r      <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frm_r  <= frm_nxt;
    line_r <= line_nxt;
    end_r  <= end_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_line_bit = line_r;
  assign out_run_end  = end_r;

endmodule

`default_nettype wire

// File: hdl/clsf_checker.sv
// ----------------------------------------------------------------------------
// clsf_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "clocked_serial_loader_framer_core_macros.svh"

module clsf_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_line_bit,
  input wire logic out_run_end
);

  `CLSF_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "stalled word dropped")
  `CLSF_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_line_bit) && $stable(out_run_end), "stalled word changed")
  // every run ends on a stop bit or an idle mark
  `CLSF_ASSERT(a_end_is_mark, clk, rst_n, out_valid && out_run_end |-> out_line_bit, "run ended on a space")
  `CLSF_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind clocked_serial_loader_framer_core clsf_checker u_clsf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_line_bit (out_ch.line_bit),
  .out_run_end  (out_ch.run_end)
);

`default_nettype wire

// File: dv/clocked_serial_loader_framer_core_test.sv
// ----------------------------------------------------------------------------
// clocked_serial_loader_framer_core_test
// Self-checking bench for the serial loader framer: drives begin, data, idle
// and spare words with random gaps and back-pressure. It predicts every bit
// period of the serial line from its own copy of the address, length and
// checksum, and compares each result word with the oldest predicted one.
// ----------------------------------------------------------------------------
module clocked_serial_loader_framer_core_test;
  import clsf_pkg::*;

  // codes outside the package enums, driven on purpose
  localparam logic [1:0] KIND_SPARE    = 2'd3;
  localparam logic [1:0] REG_SPARE_LO  = 2'd2;
  localparam logic [1:0] REG_SPARE_HI  = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 50;

  // one input word as queued for the driver
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_v;
    logic       last;
  } load_word_t;

  // one bit period of the serial line
  typedef struct packed {
    logic line_bit;
    logic run_end;
  } line_bit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  clsf_in_if  in_ch ();
  clsf_out_if out_ch ();
  clsf_cfg_if cfg_ch ();

  clocked_serial_loader_framer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  // ---- predictor state: own copy of the registers and the checksum ----
  logic [ADDR_W-1:0] start_addr = START_ADDR_RST;
  logic [LEN_W-1:0]  image_len  = IMAGE_LEN_RST;
  logic [7:0]        load_sum   = 8'h00;

  load_word_t word_q[$];   // words waiting for the driver
  line_bit_t  line_q[$];   // predicted bit periods, oldest first

  int unsigned faults    = 0;
  int unsigned in_gap    = 0;
  int unsigned out_stall = 0;
  bit          calm      = 1'b0;  // no idling on either side while set

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // start bit, eight data bits LSB first, two stop bits
  function automatic void push_frame(input logic [7:0] val);
    line_q.push_back('{line_bit: 1'b0, run_end: 1'b0});
    for (int i = 0; i < 8; i++) line_q.push_back('{line_bit: val[i], run_end: 1'b0});
    repeat (2) line_q.push_back('{line_bit: 1'b1, run_end: 1'b0});
  endfunction

  // ---- driver: presents queued words, predicts on acceptance ----
  always @(posedge clk) begin : drive_words
    logic [15:0] span;
    logic [15:0] last_addr;
    load_word_t  w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.kind)
          KIND_BEGIN: begin
            // length above the bound is clamped; zero length wraps below start
            if ({2'b00, image_len} > MAX_IMAGE) span = MAX_IMAGE[15:0];
            else span = {1'b0, image_len};
            last_addr = start_addr + span - 16'd1;
            push_frame(start_addr[15:8]);
            push_frame(start_addr[7:0]);
            push_frame(last_addr[15:8]);
            push_frame(last_addr[7:0]);
            load_sum = start_addr[15:8] + start_addr[7:0] + last_addr[15:8] + last_addr[7:0];
          end
          KIND_DATA: begin
            // no begin needed: the byte just adds to whatever the sum holds
            push_frame(in_ch.data_byte);
            load_sum = load_sum + in_ch.data_byte;
            if (in_ch.final_byte) push_frame(8'h00 - load_sum);
          end
          KIND_IDLE: begin
            line_q.push_back('{line_bit: 1'b1, run_end: 1'b0});
          end
          default: ;  // spare kind: dropped, no bits, sum untouched
        endcase
        if (in_ch.kind != KIND_SPARE) line_q[line_q.size()-1].run_end = 1'b1;
      end
      // slot is free once the current word has gone
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap != 0 || word_q.size() == 0) begin
          if (in_gap != 0) in_gap--;
          in_ch.valid <= 1'b0;
        end else begin
          w = word_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.kind       <= w.kind;
          in_ch.data_byte  <= w.data_v;
          in_ch.final_byte <= w.last;
          in_gap = calm ? 0 : pick_gap();
        end
      end
    end
  end

  // ---- monitor: checks each result word, throttles ready ----
  always @(posedge clk) begin : check_line
    line_bit_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (line_q.size() == 0) begin
          $error("result word with nothing predicted: line_bit %0b run_end %0b",
                 out_ch.line_bit, out_ch.run_end);
          faults++;
        end else begin
          e = line_q.pop_front();
          if (out_ch.line_bit !== e.line_bit) begin
            $error("line_bit: expected %0b, got %0b", e.line_bit, out_ch.line_bit);
            faults++;
          end
          if (out_ch.run_end !== e.run_end) begin
            $error("run_end: expected %0b, got %0b", e.run_end, out_ch.run_end);
            faults++;
          end
        end
      end
      if (out_stall != 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) out_stall = pick_gap();
      end
    end
  end

  // ---- register writes seen by the predictor ----
  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_START_ADDRESS: start_addr = cfg_ch.data;
        REG_IMAGE_LENGTH:  image_len  = cfg_ch.data[LEN_W-1:0];
        default: ;  // beyond the two registers: no effect
      endcase
    end
  end

  task automatic queue_word(input logic [1:0] kind, input logic [7:0] val,
                            input logic last);
    word_q.push_back('{kind: kind, data_v: val, last: last});
  endtask

  // header, n data bytes, checksum on the last one
  task automatic queue_image(input int unsigned n);
    queue_word(KIND_BEGIN, 8'($urandom), 1'($urandom));
    for (int unsigned i = 1; i <= n; i++) queue_word(KIND_DATA, 8'($urandom), i == n);
  endtask

  // wait until the driver has emptied and every predicted bit has arrived
  task automatic settle();
    while (word_q.size() != 0 || in_ch.valid || line_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
  endtask

  // ---- stimulus ----
  initial begin
    int unsigned count;
    int unsigned r;
    logic [15:0] len_v;

    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_IDLE;
    in_ch.data_byte  = 8'h00;
    in_ch.final_byte = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_START_ADDRESS;
    cfg_ch.data      = 16'h0000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, sums carried across, spare kind
    queue_word(KIND_IDLE,  8'h00, 1'b1);
    queue_word(KIND_BEGIN, 8'hff, 1'b1);
    queue_word(KIND_DATA,  8'h00, 1'b0);
    queue_word(KIND_DATA,  8'hff, 1'b0);
    queue_word(KIND_DATA,  8'ha5, 1'b1);
    queue_word(KIND_DATA,  8'h3c, 1'b0);  // after the final byte, no new header
    queue_word(KIND_DATA,  8'h81, 1'b1);
    queue_word(KIND_SPARE, 8'hff, 1'b1);
    queue_word(KIND_IDLE,  8'h00, 1'b0);
    settle();

    // zero length: end address one below start, wrapped
    write_reg(REG_START_ADDRESS, 16'h0000);
    write_reg(REG_IMAGE_LENGTH,  16'h0000);
    queue_word(KIND_BEGIN, 8'h00, 1'b0);
    queue_word(KIND_DATA,  8'h55, 1'b1);
    settle();

    // top address with the largest length, end wraps past 0xffff
    write_reg(REG_START_ADDRESS, 16'hffff);
    write_reg(REG_IMAGE_LENGTH,  16'd16384);
    queue_word(KIND_BEGIN, 8'h00, 1'b0);
    queue_word(KIND_DATA,  8'haa, 1'b1);
    settle();

    // just above the bound, then all length bits set (bit 15 dropped)
    write_reg(REG_IMAGE_LENGTH, 16'd16385);
    queue_word(KIND_BEGIN, 8'h00, 1'b0);
    settle();
    write_reg(REG_IMAGE_LENGTH, 16'hffff);
    queue_word(KIND_BEGIN, 8'h00, 1'b0);
    queue_word(KIND_DATA,  8'h01, 1'b1);
    settle();

    // writes to unused indexes must change nothing
    write_reg(REG_SPARE_LO, 16'h1234);
    write_reg(REG_SPARE_HI, 16'hedcb);
    queue_word(KIND_BEGIN, 8'h00, 1'b0);
    settle();

    write_reg(REG_START_ADDRESS, 16'h1234);
    write_reg(REG_IMAGE_LENGTH,  16'd2);
    queue_word(KIND_BEGIN, 8'h00, 1'b0);
    queue_word(KIND_DATA,  8'hfe, 1'b0);
    queue_word(KIND_DATA,  8'h7f, 1'b1);

    // random phases: mostly whole images with preamble, some noise
    for (int p = 0; p < 6; p++) begin
      // sender holds off here until every predicted bit has come
      settle();
      case (p)
        0: write_reg(REG_START_ADDRESS, 16'h0000);
        1: write_reg(REG_START_ADDRESS, 16'hffff);
        default: write_reg(REG_START_ADDRESS, 16'($urandom));
      endcase
      r = $urandom_range(0, 3);
      if (p == 0) len_v = 16'd1;
      else if (p == 1) len_v = 16'd16384;
      else if (r == 0) len_v = 16'($urandom);
      else len_v = 16'($urandom_range(1, 16384));
      write_reg(REG_IMAGE_LENGTH, len_v);
      calm = (p == 2);
      count = 0;
      while (count < 54) begin
        r = $urandom_range(0, 9);
        if (r < 8) begin
          repeat ($urandom_range(0, 3)) begin
            queue_word(KIND_IDLE, 8'($urandom), 1'($urandom));
            count++;
          end
          len_v = 16'($urandom_range(1, 8));
          queue_image(32'(len_v));
          count += 32'(len_v) + 32'd1;
        end else if (r == 8) begin
          queue_word(2'($urandom), 8'($urandom), 1'($urandom));
          count++;
        end else begin
          // broken run: stray bytes with random final flags
          repeat ($urandom_range(1, 3)) begin
            queue_word(KIND_DATA, 8'($urandom), 1'($urandom));
            count++;
          end
        end
      end
    end
    calm = 1'b0;

    settle();
    if (line_q.size() != 0) begin
      $error("%0d predicted bit periods never arrived", line_q.size());
      faults++;
    end
    if (faults == 0) begin
      $display("PASS clocked_serial_loader_framer_core");
    end else begin
      $display("FAIL clocked_serial_loader_framer_core");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #40000000;
    $display("FAIL clocked_serial_loader_framer_core");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/clsf_pkg.sv
hdl/clsf_in_if.sv
hdl/clsf_out_if.sv
hdl/clsf_cfg_if.sv
hdl/clsf_serializer.sv
hdl/clocked_serial_loader_framer_core.sv
hdl/clsf_checker.sv
dv/clocked_serial_loader_framer_core_test.sv
